/* sv/gpfe_pkg.sv */
// ---------------------------------------------------------------------------
// gpfe_pkg
// Constants and small digit helpers for the GPS position frame encoder.
// ---------------------------------------------------------------------------
package gpfe_pkg;

  localparam int NSTG = 8;

  localparam int LAT_LIMIT = 90000;
  localparam int LON_LIMIT = 180000;

  localparam logic [7:0] MARK_HI = 8'h50;
  localparam logic [7:0] MARK_LO = 8'h30;

  localparam logic [7:0] OFS_BAND0 = 8'h76;
  localparam logic [7:0] OFS_BAND_LOW = 8'h26;
  localparam logic [7:0] OFS_BAND2 = 8'h6C;
  localparam logic [7:0] OFS_MIN_LOW = 8'h58;
  localparam logic [7:0] OFS_HUND = 8'h1C;

  // x / 1000 ~= (x * 1048) >> 20, low by at most one for x below ~1.8M
  localparam int DIV_K = 1000;
  localparam int RECIP_K = 1048;
  localparam int RECIP_SH = 20;

  // m / 100 == (m * 5243) >> 19, exact for m below 43699
  localparam int DIV100_MUL = 5243;
  localparam int DIV100_SH = 19;

  // exact v / 10 for v up to 255
  function automatic logic [7:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd205;
    return 8'(p >> 11);
  endfunction

  function automatic logic [7:0] mod10(input logic [7:0] v);
    logic [7:0] t;
    t = div10(v);
    return v - 8'(t * 8'd10);
  endfunction

endpackage

/* sv/gpfe_div1000.sv */
// ---------------------------------------------------------------------------
// gpfe_div1000
// Two-stage divide by 1000: reciprocal multiply, then one correction step.
// ---------------------------------------------------------------------------
module gpfe_div1000 #(
  parameter int XW = 18
) (
  input  logic            clk,
  input  logic [1:0]      load,
  input  logic [XW-1:0]   x,
  output logic [XW-10:0]  q,
  output logic [9:0]      r
);
  import gpfe_pkg::*;

  logic [XW+10:0] prod;
  logic [XW-1:0]  xa;
  logic [XW-10:0] q0;
  logic [XW-1:0]  r0;

  always_ff @(posedge clk) begin
    if (load[0]) begin
      prod <= (XW+11)'(x) * (XW+11)'(RECIP_K);
      xa   <= x;
    end
  end

  always_comb begin
    q0 = prod[XW+10:RECIP_SH];
    r0 = xa - XW'(XW'(q0) * XW'(DIV_K));
  end

  // estimate is never high, and at most one low
  always_ff @(posedge clk) begin
    if (load[1]) begin
      if (r0 >= XW'(DIV_K)) begin
        q <= q0 + 1'b1;
        r <= 10'(r0 - XW'(DIV_K));
      end else begin
        q <= q0;
        r <= 10'(r0);
      end
    end
  end

endmodule

/* sv/gps_position_frame_encoder_top.sv */
// ---------------------------------------------------------------------------
// gps_position_frame_encoder_top
// Latitude/longitude to Mic-E style position bytes plus frame checksum.
// ---------------------------------------------------------------------------
// Throughput: one item per cycle unless out_ready stalls; eight register stages, each
// with its own valid bit, so a stalled output only holds the stages that are full.
// Reset clears all stage valid bits; payload registers are not reset.
module gps_position_frame_encoder_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [17:0] latitude_milli,
  input  logic signed [18:0] longitude_milli,
  input  logic [39:0]        head_bytes,
  input  logic [39:0]        tail_bytes,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         lat_tens_byte,
  output logic [7:0]         lat_units_byte,
  output logic [7:0]         lat_min_tens_byte,
  output logic [7:0]         lat_min_units_byte,
  output logic [7:0]         lat_frac_tens_byte,
  output logic [7:0]         lat_frac_units_byte,
  output logic [7:0]         lon_degree_byte,
  output logic [7:0]         lon_minute_byte,
  output logic [7:0]         lon_hundredth_byte,
  output logic [7:0]         frame_checksum
);
  import gpfe_pkg::*;

  logic [NSTG:1]   v;
  logic [NSTG+1:1] rdy;

  always_comb begin
    rdy[NSTG+1] = out_ready;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[1]) v[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = v[NSTG];

  // ---- stage 1: clamp, magnitude, side bytes sum
  logic signed [17:0] lat_c;
  logic signed [18:0] lon_c;
  logic [7:0]         side_sum;
  logic [16:0]        s1_la;
  logic [17:0]        s1_lo;
  logic               s1_south, s1_west;
  logic [7:0]         s1_sum;

  always_comb begin
    if (latitude_milli > 18'sd90000)       lat_c = 18'sd90000;
    else if (latitude_milli < -18'sd90000) lat_c = -18'sd90000;
    else                                    lat_c = latitude_milli;
    if (longitude_milli > 19'sd180000)       lon_c = 19'sd180000;
    else if (longitude_milli < -19'sd180000) lon_c = -19'sd180000;
    else                                      lon_c = longitude_milli;
    side_sum = '0;
    for (int i = 0; i < 5; i++) begin
      side_sum = side_sum + head_bytes[8*i +: 8] + tail_bytes[8*i +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_south <= lat_c < 0;
      s1_west  <= lon_c < 0;
      s1_la    <= (lat_c < 0) ? 17'(-lat_c) : 17'(lat_c);
      s1_lo    <= (lon_c < 0) ? 18'(-lon_c) : 18'(lon_c);
      s1_sum   <= side_sum;
    end
  end

  // ---- stages 2-3: split degrees from thousandths
  logic [7:0] lat_q;
  logic [8:0] lon_q;
  logic [9:0] lat_r, lon_r;

  gpfe_div1000 #(.XW(17)) u_lat_div (
    .clk  (clk),
    .load (rdy[3:2]),
    .x    (s1_la),
    .q    (lat_q),
    .r    (lat_r)
  );

  gpfe_div1000 #(.XW(18)) u_lon_div (
    .clk  (clk),
    .load (rdy[3:2]),
    .x    (s1_lo),
    .q    (lon_q),
    .r    (lon_r)
  );

  logic       s2_south, s2_west, s3_south, s3_west;
  logic [7:0] s2_sum, s3_sum;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_south <= s1_south;
      s2_west  <= s1_west;
      s2_sum   <= s1_sum;
    end
    if (rdy[3]) begin
      s3_south <= s2_south;
      s3_west  <= s2_west;
      s3_sum   <= s2_sum;
    end
  end

  // ---- stage 4: latitude degree digits, longitude band, minutes x6
  logic [7:0]  lat_mark, lon_mark, g, band, code;
  logic [7:0]  s4_lat_mark, s4_lon_mark, s4_b0, s4_b1, s4_b6, s4_band, s4_sum;
  logic [12:0] s4_lat_m, s4_lon_m;

  always_comb begin
    lat_mark = s3_south ? MARK_LO : MARK_HI;
    lon_mark = s3_west ? MARK_HI : MARK_LO;
    g = 8'(lon_q);
    if (g <= 8'd9) begin
      band = MARK_HI;
      code = g + OFS_BAND0;
    end else if (g <= 8'd99) begin
      band = MARK_LO;
      code = g - 8'd10 + OFS_BAND_LOW;
    end else if (g <= 8'd109) begin
      band = MARK_HI;
      code = g - 8'd100 + OFS_BAND2;
    end else begin
      band = MARK_HI;
      code = g - 8'd110 + OFS_BAND_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_lat_mark <= lat_mark;
      s4_lon_mark <= lon_mark;
      s4_b0       <= div10(lat_q) | lat_mark;
      s4_b1       <= mod10(lat_q) | lat_mark;
      s4_b6       <= code | lon_mark;
      s4_band     <= band;
      s4_lat_m    <= 13'(lat_r) * 13'd6;
      s4_lon_m    <= 13'(lon_r) * 13'd6;
      s4_sum      <= s3_sum;
    end
  end

  // ---- stage 5: minutes / 100
  logic [25:0] lat_hp, lon_hp;
  logic [12:0] s5_lat_m, s5_lon_m;
  logic [5:0]  s5_lat_h, s5_lon_h;
  logic [7:0]  s5_lat_mark, s5_lon_mark, s5_b0, s5_b1, s5_b6, s5_band, s5_sum;

  always_comb begin
    lat_hp = 26'(s4_lat_m) * 26'(DIV100_MUL);
    lon_hp = 26'(s4_lon_m) * 26'(DIV100_MUL);
  end

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_lat_m    <= s4_lat_m;
      s5_lon_m    <= s4_lon_m;
      s5_lat_h    <= 6'(lat_hp >> DIV100_SH);
      s5_lon_h    <= 6'(lon_hp >> DIV100_SH);
      s5_lat_mark <= s4_lat_mark;
      s5_lon_mark <= s4_lon_mark;
      s5_b0       <= s4_b0;
      s5_b1       <= s4_b1;
      s5_b6       <= s4_b6;
      s5_band     <= s4_band;
      s5_sum      <= s4_sum;
    end
  end

  // ---- stage 6: minute digits, hundredths
  logic [6:0] lon_frac;
  logic [7:0] lon_min;
  logic [6:0] s6_lat_frac;
  logic [7:0] s6_b0, s6_b1, s6_b2, s6_b3, s6_b6, s6_b7, s6_b8;
  logic [7:0] s6_band, s6_lon_mark, s6_sum;

  always_comb begin
    lon_frac = 7'(s5_lon_m - 13'(s5_lon_h) * 13'd100);
    lon_min  = 8'(s5_lon_h);
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_lat_frac <= 7'(s5_lat_m - 13'(s5_lat_h) * 13'd100);
      s6_b2       <= div10(8'(s5_lat_h)) | s5_lat_mark;
      s6_b3       <= mod10(8'(s5_lat_h)) | s5_lat_mark;
      s6_b7       <= (lon_min <= 8'd9) ? lon_min + OFS_MIN_LOW
                                       : lon_min - 8'd10 + OFS_BAND_LOW;
      s6_b8       <= 8'(lon_frac) + OFS_HUND;
      s6_b0       <= s5_b0;
      s6_b1       <= s5_b1;
      s6_b6       <= s5_b6;
      s6_band     <= s5_band;
      s6_lon_mark <= s5_lon_mark;
      s6_sum      <= s5_sum;
    end
  end

  // ---- stage 7: hundredths digits, partial checksum
  logic [7:0] s7_b0, s7_b1, s7_b2, s7_b3, s7_b4, s7_b5, s7_b6, s7_b7, s7_b8;
  logic [7:0] s7_sum;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      s7_b4  <= div10(8'(s6_lat_frac)) | s6_band;
      s7_b5  <= mod10(8'(s6_lat_frac)) | s6_lon_mark;
      s7_b0  <= s6_b0;
      s7_b1  <= s6_b1;
      s7_b2  <= s6_b2;
      s7_b3  <= s6_b3;
      s7_b6  <= s6_b6;
      s7_b7  <= s6_b7;
      s7_b8  <= s6_b8;
      s7_sum <= s6_sum + s6_b0 + s6_b1 + s6_b2 + s6_b3 + s6_b6 + s6_b7 + s6_b8;
    end
  end

  // ---- stage 8: output register
  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      lat_tens_byte       <= s7_b0;
      lat_units_byte      <= s7_b1;
      lat_min_tens_byte   <= s7_b2;
      lat_min_units_byte  <= s7_b3;
      lat_frac_tens_byte  <= s7_b4;
      lat_frac_units_byte <= s7_b5;
      lon_degree_byte     <= s7_b6;
      lon_minute_byte     <= s7_b7;
      lon_hundredth_byte  <= s7_b8;
      frame_checksum      <= s7_sum + s7_b4 + s7_b5;
    end
  end

  // ---- checks
  a_full_when_blocked: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (&v))
    else $error("input blocked while a stage is empty");

  a_lat_marker_same: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lat_units_byte[7:4] == lat_tens_byte[7:4]) &&
                  (lat_min_units_byte[7:4] == lat_tens_byte[7:4]))
    else $error("latitude markers disagree");

  a_lat_tens_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lat_tens_byte[3:0] <= 4'd9))
    else $error("latitude tens digit out of range");

  a_min_tens_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (lat_min_tens_byte[3:0] <= 4'd5))
    else $error("minutes tens digit out of range");

endmodule
